// ===== src/pia_pkg.sv =====
// Shared constants for the pixelwise image arithmetic block.
package pia_pkg;

  localparam int PIXEL_WIDTH_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int CFG_INDEX_WIDTH = 2;
  localparam int OP_WIDTH        = 4;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_OPERATION     = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LEFT_SOURCE   = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_LEFT_CONSTANT = 2'd2;

  localparam logic [OP_WIDTH-1:0] OP_ADD     = 4'd0;
  localparam logic [OP_WIDTH-1:0] OP_SUB     = 4'd1;
  localparam logic [OP_WIDTH-1:0] OP_MUL     = 4'd2;
  localparam logic [OP_WIDTH-1:0] OP_DIV     = 4'd3;
  localparam logic [OP_WIDTH-1:0] OP_ABSDIFF = 4'd4;
  localparam logic [OP_WIDTH-1:0] OP_HYPOT   = 4'd5;
  localparam logic [OP_WIDTH-1:0] OP_MIN     = 4'd6;
  localparam logic [OP_WIDTH-1:0] OP_MAX     = 4'd7;
  localparam logic [OP_WIDTH-1:0] OP_LESS    = 4'd8;
  localparam logic [OP_WIDTH-1:0] OP_GREATER = 4'd9;
  localparam logic [OP_WIDTH-1:0] OP_EQUAL   = 4'd10;

endpackage

// ===== src/pia_core.sv =====
// Arithmetic pipeline: decode, multiply, bit-serial divide and square root, clamp.
module pia_core import pia_pkg::*; #(
  parameter int PIXEL_WIDTH   = PIXEL_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic [PIXEL_WIDTH-1:0] la,
  input  logic [PIXEL_WIDTH-1:0] rb,
  input  logic [OP_WIDTH-1:0]    op,
  output logic                   out_vld,
  output logic [PIXEL_WIDTH-1:0] res,
  output logic                   sat,
  output logic                   dz
);

  localparam int W    = PIXEL_WIDTH;
  localparam int F    = FRACTION_BITS;
  localparam int H    = (W + 1) / 2;
  localparam int DW   = 2 * W;
  localparam int QW   = W + F;
  localparam int EW   = (DW + 2 > QW + 2) ? DW + 2 : QW + 2;
  localparam int LAST = ((QW + 2 > W + 5) ? QW + 2 : W + 5) + 1;
  localparam logic [DW-1:0] HALF = (F > 0) ? (DW'(1) << ((F > 0) ? F - 1 : 0)) : '0;

  typedef struct packed {
    logic                 vld;
    logic                 an;
    logic                 bn;
    logic [W-1:0]         am;
    logic [W-1:0]         bm;
    logic [W-1:0]         la;
    logic [W-1:0]         rb;
    logic                 lt;
    logic                 gt;
    logic                 eq;
    logic [W-1:0]         sres;
    logic                 ssat;
    logic                 dz;
    logic [3:0][2*H-1:0]  pab;
    logic [3:0][2*H-1:0]  paa;
    logic [3:0][2*H-1:0]  pbb;
    logic [DW-1:0]        prod;
    logic [DW-1:0]        sqx;
    logic [DW-1:0]        sqr;
    logic [W-1:0]         qres;
    logic                 qsat;
    logic [QW-1:0]        dn;
    logic [W-1:0]         dr;
    logic [QW-1:0]        dq;
    logic [QW:0]          dqr;
    logic [W-1:0]         dres;
    logic                 dsat;
  } stage_t;

  stage_t pipe_r   [0:LAST];
  stage_t pipe_nxt [0:LAST];

  function automatic logic [W:0] enc(input logic [EW-1:0] mag, input logic neg);
    logic [EW-1:0] lim;
    logic [W-1:0]  m;
    logic          s;
    begin
      lim = neg ? (EW'(1) << (W - 1)) : ((EW'(1) << (W - 1)) - EW'(1));
      if (mag > lim) begin
        m = lim[W-1:0];
        s = 1'b1;
      end else begin
        m = mag[W-1:0];
        s = 1'b0;
      end
      enc = {s, neg ? (-m) : m};
    end
  endfunction

  function automatic logic [DW-1:0] psum(input logic [3:0][2*H-1:0] pp);
    begin
      psum = DW'(pp[0]) + ((DW'(pp[1]) + DW'(pp[2])) << H) + (DW'(pp[3]) << (2 * H));
    end
  endfunction

  always_comb begin
    stage_t n0;
    n0     = '0;
    n0.vld = in_vld;
    n0.la  = la;
    n0.rb  = rb;
    n0.an  = la[W-1];
    n0.bn  = rb[W-1];
    n0.am  = la[W-1] ? (-la) : la;
    n0.bm  = rb[W-1] ? (-rb) : rb;
    n0.lt  = $signed(la) < $signed(rb);
    n0.gt  = $signed(la) > $signed(rb);
    n0.eq  = la == rb;
    n0.dn  = QW'(n0.am) << F;
    pipe_nxt[0] = n0;
  end

  for (genvar k = 1; k <= LAST; k++) begin : g_stage
    localparam int SB = (k >= 4 && k <= W + 3) ? 2 * (W + 3 - k) : 0;

    always_comb begin
      stage_t              p;
      stage_t              n;
      logic [W:0]          r2;
      logic [DW-1:0]       bitv;
      logic [DW-1:0]       t;
      logic signed [W:0]   sum;
      logic signed [W:0]   dif;
      logic [W:0]          smag;
      logic [W:0]          dmag;
      logic [H-1:0]        al;
      logic [H-1:0]        bl;
      logic [W-H-1:0]      ah;
      logic [W-H-1:0]      bh;
      p    = pipe_r[k-1];
      n    = p;
      r2   = {p.dr, p.dn[QW-1]};
      bitv = DW'(1) << SB;
      t    = p.sqr + bitv;
      sum  = $signed({p.la[W-1], p.la}) + $signed({p.rb[W-1], p.rb});
      dif  = $signed({p.la[W-1], p.la}) - $signed({p.rb[W-1], p.rb});
      smag = sum[W] ? (-sum) : sum;
      dmag = dif[W] ? (-dif) : dif;
      al   = p.am[H-1:0];
      ah   = p.am[W-1:H];
      bl   = p.bm[H-1:0];
      bh   = p.bm[W-1:H];

      if (k == 1) begin
        n.sres = '0;
        n.ssat = 1'b0;
        n.dz   = 1'b0;
        unique case (op)
          OP_ADD:     {n.ssat, n.sres} = enc(EW'(smag), sum[W]);
          OP_SUB:     {n.ssat, n.sres} = enc(EW'(dmag), dif[W]);
          OP_ABSDIFF: {n.ssat, n.sres} = enc(EW'(dmag), 1'b0);
          OP_MIN:     n.sres = p.lt ? p.la : p.rb;
          OP_MAX:     n.sres = p.gt ? p.la : p.rb;
          OP_LESS:    if (p.lt) {n.ssat, n.sres} = enc(EW'(1) << F, 1'b0);
          OP_GREATER: if (p.gt) {n.ssat, n.sres} = enc(EW'(1) << F, 1'b0);
          OP_EQUAL:   if (p.eq) {n.ssat, n.sres} = enc(EW'(1) << F, 1'b0);
          default: ;
        endcase
        n.pab[0] = (2*H)'(al) * (2*H)'(bl);
        n.pab[1] = (2*H)'(al) * (2*H)'(bh);
        n.pab[2] = (2*H)'(ah) * (2*H)'(bl);
        n.pab[3] = (2*H)'(ah) * (2*H)'(bh);
        n.paa[0] = (2*H)'(al) * (2*H)'(al);
        n.paa[1] = (2*H)'(al) * (2*H)'(ah);
        n.paa[2] = (2*H)'(ah) * (2*H)'(al);
        n.paa[3] = (2*H)'(ah) * (2*H)'(ah);
        n.pbb[0] = (2*H)'(bl) * (2*H)'(bl);
        n.pbb[1] = (2*H)'(bl) * (2*H)'(bh);
        n.pbb[2] = (2*H)'(bh) * (2*H)'(bl);
        n.pbb[3] = (2*H)'(bh) * (2*H)'(bh);
      end

      // squares parked in the root registers until summed
      if (k == 2) begin
        n.prod = psum(p.pab);
        n.sqx  = psum(p.paa);
        n.sqr  = psum(p.pbb);
      end

      if (k == 3) begin
        n.sqx  = p.sqx + p.sqr;
        n.sqr  = '0;
        n.prod = (p.prod + HALF) >> F;
      end

      if (k == 4 && op == OP_MUL) begin
        {n.ssat, n.sres} = enc(EW'(p.prod), p.an ^ p.bn);
      end

      if (k >= 4 && k <= W + 3) begin
        if (p.sqx >= t) begin
          n.sqx = p.sqx - t;
          n.sqr = (p.sqr >> 1) + bitv;
        end else begin
          n.sqr = p.sqr >> 1;
        end
      end

      if (k == W + 4 && p.sqx > p.sqr) begin
        n.sqr = p.sqr + DW'(1);
      end

      if (k == W + 5) begin
        {n.qsat, n.qres} = enc(EW'(p.sqr), 1'b0);
      end

      if (k <= QW) begin
        n.dn = p.dn << 1;
        if (r2 >= {1'b0, p.bm}) begin
          n.dr = W'(r2 - {1'b0, p.bm});
          n.dq = {p.dq[QW-2:0], 1'b1};
        end else begin
          n.dr = r2[W-1:0];
          n.dq = {p.dq[QW-2:0], 1'b0};
        end
      end

      if (k == QW + 1) begin
        n.dqr = {1'b0, p.dq} + (QW+1)'({p.dr, 1'b0} >= {1'b0, p.bm});
      end

      if (k == QW + 2) begin
        {n.dsat, n.dres} = enc(EW'(p.dqr), p.an ^ p.bn);
      end

      if (k == LAST) begin
        unique case (op)
          OP_DIV: begin
            if (p.bm == '0) begin
              n.dz   = 1'b1;
              n.ssat = p.am != '0;
              if (p.am == '0) begin
                n.sres = '0;
              end else begin
                n.sres = p.an ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
              end
            end else begin
              n.sres = p.dres;
              n.ssat = p.dsat;
            end
          end
          OP_HYPOT: begin
            n.sres = p.qres;
            n.ssat = p.qsat;
          end
          default: ;
        endcase
      end

      pipe_nxt[k] = n;
    end
  end

  for (genvar k = 0; k <= LAST; k++) begin : g_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pipe_r[k].vld <= 1'b0;
      end else if (en) begin
        pipe_r[k] <= pipe_nxt[k];
      end
    end
  end

  assign out_vld = pipe_r[LAST].vld;
  assign res     = pipe_r[LAST].sres;
  assign sat     = pipe_r[LAST].ssat;
  assign dz      = pipe_r[LAST].dz;

endmodule

// ===== src/pixelwise_image_arithmetic.sv =====
// Top level of the pixelwise image arithmetic block: config registers and handshake.
//
// Input channel in_valid/in_ready carries one left/right pixel pair per item;
// the result channel out_valid/out_ready returns one result pixel with its
// saturated and divide_by_zero flags per item, in order.
// The config channel cfg_valid/cfg_ready writes operation (index 0),
// left_source (index 1) or left_constant (index 2); cfg_ready is always high.
// Write config only while no item is in flight.
// Throughput: one item per cycle unless out_ready stalls the pipeline. The
// pipeline depth from acceptance to out_valid is set by the restoring
// divider, one quotient bit per stage, and the square root, one root bit
// per stage.
// Reset clears the config registers and the pipeline valid bits.
// When the receiver holds out_ready low with out_valid high, the whole
// pipeline freezes and in_ready drops; a result holds steady until taken.
module pixelwise_image_arithmetic import pia_pkg::*; #(
  parameter int PIXEL_WIDTH   = PIXEL_WIDTH_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [PIXEL_WIDTH-1:0]     cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [PIXEL_WIDTH-1:0]     in_left_pixel,
  input  logic [PIXEL_WIDTH-1:0]     in_right_pixel,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [PIXEL_WIDTH-1:0]     out_result_pixel,
  output logic                       out_saturated,
  output logic                       out_divide_by_zero
);

  logic [OP_WIDTH-1:0]    op_r;
  logic                   lsrc_r;
  logic [PIXEL_WIDTH-1:0] lconst_r;
  logic [PIXEL_WIDTH-1:0] left_term;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r     <= '0;
      lsrc_r   <= 1'b0;
      lconst_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_OPERATION:     op_r     <= cfg_data[OP_WIDTH-1:0];
        CFG_LEFT_SOURCE:   lsrc_r   <= cfg_data[0];
        CFG_LEFT_CONSTANT: lconst_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign left_term = lsrc_r ? lconst_r : in_left_pixel;
  assign in_ready  = !out_valid || out_ready;

  pia_core #(
    .PIXEL_WIDTH   (PIXEL_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (in_ready),
    .in_vld  (in_valid),
    .la      (left_term),
    .rb      (in_right_pixel),
    .op      (op_r),
    .out_vld (out_valid),
    .res     (out_result_pixel),
    .sat     (out_saturated),
    .dz      (out_divide_by_zero)
  );

endmodule

// ===== src/pia_checker.sv =====
// Port-level assertions for the pixelwise image arithmetic block, with bind.
module pia_checker import pia_pkg::*; #(
  parameter int PIXEL_WIDTH = PIXEL_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [PIXEL_WIDTH-1:0] out_result_pixel,
  input logic                   out_saturated,
  input logic                   out_divide_by_zero
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_pixel))
    else $error("stalled result changed");

  a_dz_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_divide_by_zero |-> ((out_result_pixel == '0) == !out_saturated))
    else $error("divide by zero result and saturation disagree");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind pixelwise_image_arithmetic pia_checker #(.PIXEL_WIDTH(PIXEL_WIDTH)) u_chk (.*);

// ===== sim/tb_top.sv =====
// Testbench for the pixelwise image arithmetic block: directed and random pixel pairs.
`timescale 1ns / 1ps

module tb_top;
  import pia_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam logic [31:0] PIX_MAX = 32'h7fff_ffff;
  localparam logic [31:0] PIX_MIN = 32'h8000_0000;
  localparam logic [31:0] PIX_ONE = 32'h0001_0000;

  typedef struct packed {
    logic [31:0] pix;
    logic        sat;
    logic        dz;
  } pix_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_valid, cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [31:0] cfg_data;
  logic in_valid, in_ready;
  logic [31:0] in_left_pixel, in_right_pixel;
  logic out_valid, out_ready;
  logic [31:0] out_result_pixel;
  logic out_saturated, out_divide_by_zero;

  logic [OP_WIDTH-1:0] cur_op;
  logic cur_src;
  logic [31:0] cur_const;
  pix_result_t expected_pixels[$];
  int errors;
  int cycles;
  bit quiet;
  int stall_left;

  pixelwise_image_arithmetic dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic pix_result_t clamp_mag(bit neg, logic [63:0] mag);
    pix_result_t r;
    r.dz = 1'b0;
    r.sat = 1'b0;
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        r.pix = PIX_MIN;
        r.sat = 1'b1;
      end else begin
        r.pix = -mag[31:0];
      end
    end else if (mag > 64'h7fff_ffff) begin
      r.pix = PIX_MAX;
      r.sat = 1'b1;
    end else begin
      r.pix = mag[31:0];
    end
    return r;
  endfunction

  function automatic pix_result_t predict_pixel(logic [31:0] lp, logic [31:0] rp);
    pix_result_t r;
    longint a, b, s;
    logic [63:0] am, bm, x, q, rm, t, root;
    a = longint'($signed(cur_src ? cur_const : lp));
    b = longint'($signed(rp));
    am = (a < 0) ? -a : a;
    bm = (b < 0) ? -b : b;
    r = '0;
    case (cur_op)
      OP_ADD: begin
        s = a + b;
        r = clamp_mag(s < 0, (s < 0) ? -s : s);
      end
      OP_SUB: begin
        s = a - b;
        r = clamp_mag(s < 0, (s < 0) ? -s : s);
      end
      OP_ABSDIFF: begin
        s = a - b;
        r = clamp_mag(1'b0, (s < 0) ? -s : s);
      end
      OP_MUL: r = clamp_mag((a < 0) != (b < 0), (am * bm + 64'd32768) >> 16);
      OP_DIV: begin
        if (bm == 0) begin
          if (am != 0) r = clamp_mag(a < 0, 64'd1 << 40);
          r.dz = 1'b1;
        end else begin
          q = (am << 16) / bm;
          rm = (am << 16) % bm;
          if ((rm << 1) >= bm) q = q + 64'd1;
          r = clamp_mag((a < 0) != (b < 0), q);
        end
      end
      OP_HYPOT: begin
        x = am * am + bm * bm;
        root = 0;
        for (int i = 31; i >= 0; i--) begin
          t = root | (64'd1 << i);
          if (t * t <= x) root = t;
        end
        if (x - root * root > root) root = root + 64'd1;
        r = clamp_mag(1'b0, root);
      end
      OP_MIN: r.pix = (a < b) ? a[31:0] : b[31:0];
      OP_MAX: r.pix = (a > b) ? a[31:0] : b[31:0];
      OP_LESS: r.pix = (a < b) ? PIX_ONE : '0;
      OP_GREATER: r.pix = (a > b) ? PIX_ONE : '0;
      OP_EQUAL: r.pix = (a == b) ? PIX_ONE : '0;
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", field, got, want, cycles);
    errors++;
  endtask

  always @(posedge clk) begin
    pix_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("unexpected item", out_result_pixel, '0);
        end else begin
          want = expected_pixels.pop_front();
          if (out_result_pixel !== want.pix)
            report_mismatch("result_pixel", out_result_pixel, want.pix);
          if (out_saturated !== want.sat)
            report_mismatch("saturated", 32'(out_saturated), 32'(want.sat));
          if (out_divide_by_zero !== want.dz)
            report_mismatch("divide_by_zero", 32'(out_divide_by_zero), 32'(want.dz));
        end
      end
      if (in_valid && in_ready)
        expected_pixels.push_back(predict_pixel(in_left_pixel, in_right_pixel));
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left <= int'($urandom_range(0, 10));
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_pixel_pair(logic [31:0] lp, logic [31:0] rp);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_left_pixel <= lp;
    in_right_pixel <= rp;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    case (idx)
      CFG_OPERATION: cur_op = val[OP_WIDTH-1:0];
      CFG_LEFT_SOURCE: cur_src = val[0];
      CFG_LEFT_CONSTANT: cur_const = val;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [OP_WIDTH-1:0] op, logic src, logic [31:0] k);
    wait_idle();
    write_reg(CFG_OPERATION, 32'(op));
    write_reg(CFG_LEFT_SOURCE, 32'(src));
    write_reg(CFG_LEFT_CONSTANT, k);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_pixel();
    case ($urandom_range(0, 5))
      0: case ($urandom_range(0, 5))
           0: return PIX_MAX;
           1: return PIX_MIN;
           2: return '0;
           3: return 32'hffff_ffff;
           4: return PIX_ONE;
           default: return -PIX_ONE;
         endcase
      1: return $urandom_range(0, 32'h1f_ffff) - 32'h10_0000;
      2: return $urandom_range(0, 32'h1ff_ffff) - 32'h100_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    for (int op = 0; op <= OP_EQUAL; op++) begin
      set_config(OP_WIDTH'(op), 1'b0, '0);
      send_pixel_pair(PIX_MAX, PIX_MIN);
      send_pixel_pair(PIX_MIN, PIX_MAX);
    end
    set_config(OP_DIV, 1'b0, '0);
    send_pixel_pair(PIX_ONE, '0);
    send_pixel_pair(-PIX_ONE, '0);
    send_pixel_pair('0, '0);
    set_config(OP_EQUAL + 4'd1, 1'b1, PIX_MAX);
    send_pixel_pair(PIX_MAX, PIX_MAX);
  endtask

  task automatic test_random_phase(int count);
    logic [OP_WIDTH-1:0] op;
    logic src;
    logic [31:0] k, lp, rp;
    op = ($urandom_range(0, 9) == 0) ? OP_WIDTH'($urandom_range(OP_EQUAL + 1, 15))
                                     : OP_WIDTH'($urandom_range(0, 10));
    src = ($urandom_range(0, 3) == 0);
    k = rand_pixel();
    set_config(op, src, k);
    for (int i = 0; i < count; i++) begin
      lp = rand_pixel();
      rp = rand_pixel();
      if ($urandom_range(0, 7) == 0) rp = src ? k : lp;
      send_pixel_pair(lp, rp);
    end
  endtask

  initial begin
    quiet = 1'b0;
    cur_op = OP_ADD;
    cur_src = 1'b0;
    cur_const = '0;
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_OPERATION;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_left_pixel <= '0;
    in_right_pixel <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    for (int p = 0; p < 14; p++) test_random_phase(130);
    set_config(OP_ADD, 1'b1, PIX_MIN);
    send_pixel_pair(PIX_MAX, PIX_MIN);
    quiet = 1'b1;
    test_random_phase(100);
    wait_idle();
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/pia_pkg.sv
src/pia_core.sv
src/pixelwise_image_arithmetic.sv
src/pia_checker.sv
sim/tb_top.sv
